@@ rtl/core/mbd_pkg.sv @@
package mbd_pkg;

  // fixed field widths of the channels
  localparam int PIN_W     = 3;
  localparam int TIME_W    = 32;
  localparam int TIMEOUT_W = 8;

  // defaults for the top-level parameters
  localparam int NUM_BUTTONS_DEF  = 3;
  localparam int HISTORY_BITS_DEF = 8;
  localparam int HISTORY_MAX      = 16;

  // debounce thresholds
  localparam int PRESS_MIN    = 4;
  localparam int RELEASE_MAX  = 4;
  localparam int WAKE_HISTORY = 4;

  // timeout scaling: 5 s units in ms
  localparam int TIMEOUT_UNIT_MS = 5000;
  localparam int LIMIT_W         = 21;

  localparam int CNT_W = $clog2(HISTORY_MAX + 1);

  typedef enum logic [0:0] {
    CMD_SAMPLE = 1'b0,
    CMD_WAKE   = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [PIN_W-1:0]   pin_levels;
    logic [PIN_W-1:0]   handler_accepts;
    logic               deep_sleep;
    logic [TIME_W-1:0]  now_ms;
  } in_item_t;

  typedef struct packed {
    logic [PIN_W-1:0] handler_request;
    logic [PIN_W-1:0] press_fired;
    logic [PIN_W-1:0] beep_request;
    logic [PIN_W-1:0] held_flags;
    logic             active;
  } out_item_t;

  // per-button status handed to the top level
  typedef struct packed {
    logic req;
    logic fired;
    logic beep;
    logic held;
    logic recent;
  } btn_stat_t;

  function automatic logic [CNT_W-1:0] ones(input logic [HISTORY_MAX-1:0] v);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int k = 0; k < HISTORY_MAX; k++) begin
      n = n + CNT_W'(v[k]);
    end
    return n;
  endfunction

endpackage

@@ rtl/core/mbd_if.sv @@
interface mbd_in_if;
  logic               valid;
  logic               ready;
  mbd_pkg::in_item_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface mbd_out_if;
  logic               valid;
  logic               ready;
  mbd_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/core/mbd_button.sv @@
module mbd_button #(
  parameter int HISTORY_BITS = mbd_pkg::HISTORY_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         wake,
  input  logic                         pressed,
  input  logic                         accept,
  input  logic                         deep_sleep,
  input  logic [mbd_pkg::TIME_W-1:0]   now_ms,
  input  logic [mbd_pkg::LIMIT_W-1:0]  limit,
  output mbd_pkg::btn_stat_t           stat
);

  logic [HISTORY_BITS-1:0]        hist_r, hist_nxt, hist_shift;
  logic                           latched_r, latched_nxt;
  logic                           done_r, done_nxt;
  logic [mbd_pkg::TIME_W-1:0]     time_r, time_nxt;
  logic [mbd_pkg::TIME_W-1:0]     elapsed;
  logic [mbd_pkg::CNT_W-1:0]      cnt;

  assign hist_shift = {hist_r[HISTORY_BITS-2:0], pressed};
  assign cnt        = mbd_pkg::ones(mbd_pkg::HISTORY_MAX'(hist_shift));

  always_comb begin
    hist_nxt    = hist_shift;
    latched_nxt = latched_r;
    done_nxt    = done_r;
    time_nxt    = time_r;
    stat.req    = 1'b0;
    stat.fired  = 1'b0;
    stat.beep   = 1'b0;
    if (wake) begin
      hist_nxt    = HISTORY_BITS'(mbd_pkg::WAKE_HISTORY);
      latched_nxt = 1'b1;
      done_nxt    = 1'b1;
      time_nxt    = now_ms;
    end else if (pressed) begin
      if (cnt >= mbd_pkg::CNT_W'(mbd_pkg::PRESS_MIN)) begin
        if (!latched_r) begin
          latched_nxt = 1'b1;
          time_nxt    = now_ms;
        end
        if (!done_r) begin
          stat.req = 1'b1;
          if (accept) begin
            done_nxt   = 1'b1;
            stat.fired = 1'b1;
            stat.beep  = !deep_sleep;
          end
        end
      end
    end else if (cnt <= mbd_pkg::CNT_W'(mbd_pkg::RELEASE_MAX)) begin
      latched_nxt = 1'b0;
      done_nxt    = 1'b0;
    end
    // elapsed wraps mod 2^32, so a stamp in the future reads as long ago
    elapsed     = now_ms - time_nxt;
    stat.held   = latched_nxt;
    stat.recent = elapsed < mbd_pkg::TIME_W'(limit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r    <= '0;
      latched_r <= 1'b0;
      done_r    <= 1'b0;
      time_r    <= '0;
    end else if (en) begin
      hist_r    <= hist_nxt;
      latched_r <= latched_nxt;
      done_r    <= done_nxt;
      time_r    <= time_nxt;
    end
  end

endmodule

@@ rtl/core/multi_button_debouncer.sv @@
// Debounces NUM_BUTTONS buttons from active-low pin samples and tracks press
// handling and activity. Each request is either a sample tick or a wake
// command and yields exactly one result. The block takes one request per
// clock cycle unless the result register is stalled; a result passes through
// the input register, then the result register, and the path between them is the
// per-button history popcount plus one 32-bit elapsed-time compare per button.
// A stalled result register holds the input stage, so requests are never dropped.
// The user writes sleep_timeout through cfg_we/cfg_wdata only while the block is
// idle (not enforced by the block); a value of zero keeps active high. Only the
// first three buttons appear on the per-button fields; any others read as pressed.
module multi_button_debouncer #(
  parameter int NUM_BUTTONS  = mbd_pkg::NUM_BUTTONS_DEF,
  parameter int HISTORY_BITS = mbd_pkg::HISTORY_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  mbd_in_if.sink                         in_ch,
  mbd_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [mbd_pkg::TIMEOUT_W-1:0]  cfg_wdata
);

  localparam int N_OUT = (NUM_BUTTONS < mbd_pkg::PIN_W) ? NUM_BUTTONS : mbd_pkg::PIN_W;
  localparam logic [mbd_pkg::PIN_W-1:0] HELD_ALL = mbd_pkg::PIN_W'((1 << N_OUT) - 1);

  logic                          s1_valid_r, s1_valid_nxt;
  mbd_pkg::in_item_t             s1_item_r;
  logic                          out_valid_r, out_valid_nxt;
  mbd_pkg::out_item_t            out_item_r, out_item_nxt;
  logic [mbd_pkg::LIMIT_W-1:0]   limit_r;
  logic                          advance, fire, in_take;
  logic                          wake;
  mbd_pkg::btn_stat_t            stat [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0]        recent;

  assign advance      = !out_valid_r || out_ch.ready;
  assign fire         = s1_valid_r && advance;
  assign in_ch.ready  = !s1_valid_r || advance;
  assign in_take      = in_ch.valid && in_ch.ready;
  assign wake         = (s1_item_r.cmd == mbd_pkg::CMD_WAKE);

  assign s1_valid_nxt  = in_take ? 1'b1 : (fire ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = fire ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_btn
    logic pressed, accept;
    if (i < mbd_pkg::PIN_W) begin : g_pin
      assign pressed = !s1_item_r.pin_levels[i];
      assign accept  = s1_item_r.handler_accepts[i];
    end else begin : g_nopin
      assign pressed = 1'b1;
      assign accept  = 1'b0;
    end

    mbd_button #(
      .HISTORY_BITS (HISTORY_BITS)
    ) u_button (
      .clk        (clk),
      .rst_n      (rst_n),
      .en         (fire),
      .wake       (wake),
      .pressed    (pressed),
      .accept     (accept),
      .deep_sleep (s1_item_r.deep_sleep),
      .now_ms     (s1_item_r.now_ms),
      .limit      (limit_r),
      .stat       (stat[i])
    );

    assign recent[i] = stat[i].recent;
  end

  for (genvar j = 0; j < mbd_pkg::PIN_W; j++) begin : g_out
    if (j < NUM_BUTTONS) begin : g_on
      assign out_item_nxt.handler_request[j] = stat[j].req;
      assign out_item_nxt.press_fired[j]     = stat[j].fired;
      assign out_item_nxt.beep_request[j]    = stat[j].beep;
      assign out_item_nxt.held_flags[j]      = stat[j].held;
    end else begin : g_off
      assign out_item_nxt.handler_request[j] = 1'b0;
      assign out_item_nxt.press_fired[j]     = 1'b0;
      assign out_item_nxt.beep_request[j]    = 1'b0;
      assign out_item_nxt.held_flags[j]      = 1'b0;
    end
  end

  // zero limit only when the timeout is zero: always active
  assign out_item_nxt.active = (limit_r == '0) || (|recent);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      limit_r     <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        limit_r <= mbd_pkg::LIMIT_W'(32'(cfg_wdata) * 32'(mbd_pkg::TIMEOUT_UNIT_MS));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_ch.payload;
    end
    if (fire) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_item_r;

  a_fired_needs_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ((out_ch.payload.press_fired & ~out_ch.payload.handler_request) == '0))
    else $error("press fired without handler request");

  a_beep_needs_fire: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ((out_ch.payload.beep_request & ~out_ch.payload.press_fired) == '0))
    else $error("beep requested without a fired press");

  a_no_timeout_active: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && limit_r == '0) |-> out_ch.payload.active)
    else $error("inactive result with timeout disabled");

  a_wake_result: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && wake) |=> (out_ch.valid && out_ch.payload.held_flags == HELD_ALL
                        && out_ch.payload.handler_request == '0))
    else $error("wake result does not mark all buttons held");

endmodule
